FILE: hdl/gqt_pkg.sv
package gqt_pkg;

    // Field widths of the command, result and configuration words.
    localparam int ACT_W      = 2;
    localparam int CELL_W     = 3;
    localparam int QOUT_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;
    localparam int SIDE_CFG_W = 4;

    // Number of action values kept per cell.
    localparam int LANES = 4;

    // Command codes.
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Action codes; they also select the lane of a cell's word.
    localparam logic [ACT_W-1:0] ACT_UP    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DOWN  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TERMINAL_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOOD_ROW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAD_ROW      = 3'd4;

    // Fixed-point constants with eight fraction bits.
    localparam int FRAC_ONE   = 256;
    localparam int FRAC_TENTH = 26;

    // Control word from the sequencer to the table memory.
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [ACT_W-1:0] wr_lane;
    } tbl_ctl_t;

endpackage

FILE: hdl/gqt_cmd_if.sv
interface gqt_cmd_if import gqt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ACT_W-1:0]  action;
    logic [CELL_W-1:0] read_col;
    logic [CELL_W-1:0] read_row;

    modport source (output valid, output op, output action, output read_col,
                    output read_row, input ready);
    modport sink (input valid, input op, input action, input read_col,
                  input read_row, output ready);
endinterface

FILE: hdl/gqt_res_if.sv
interface gqt_res_if import gqt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CELL_W-1:0]        agent_col;
    logic [CELL_W-1:0]        agent_row;
    logic signed [QOUT_W-1:0] q_value;
    logic                     hit_wall;
    logic                     episode_end;

    modport source (output valid, output agent_col, output agent_row, output q_value,
                    output hit_wall, output episode_end, input ready);
    modport sink (input valid, input agent_col, input agent_row, input q_value,
                  input hit_wall, input episode_end, output ready);
endinterface

FILE: hdl/gqt_cfg_if.sv
interface gqt_cfg_if import gqt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hdl/gqt_table.sv
module gqt_table import gqt_pkg::*; #(
    parameter int DEPTH       = 64,
    parameter int ADDR_W      = 6,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbl_ctl_t                     ctl,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [VALUE_WIDTH-1:0]       wr_value,
    output logic [LANES*VALUE_WIDTH-1:0] rd_word
);

    logic [LANES*VALUE_WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0]             valid_reg;
    logic [LANES*VALUE_WIDTH-1:0] rdata_reg;
    logic                         rvalid_reg;

    // A write to an entry that was never written also clears its other lanes,
    // so one valid bit per entry stands in for the cleared table.
    always_ff @(posedge clk)
    begin
        for (int lane = 0; lane < LANES; lane++)
        begin
            if (ctl.wr_en && (ACT_W'(lane) == ctl.wr_lane || !valid_reg[addr]))
            begin
                mem[addr][lane*VALUE_WIDTH +: VALUE_WIDTH] <=
                    (ACT_W'(lane) == ctl.wr_lane) ? wr_value : '0;
            end
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rvalid_reg <= valid_reg[addr];
            end
        end
    end

    assign rd_word = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: hdl/gridworld_q_table_update.sv
// Grid-world Q-table update: one command word in, one result word out.
// An accepted command is held in the EXEC state; its result word is registered
// once the result slot is free. No new command is taken until then, as the
// single-port table memory reads the target cell, then writes the old cell's entry.
// Reset: the table reads as all zero, agent at (0,0), reward sum zero,
// configuration at its reset values; no clearing pass is needed.
module gridworld_q_table_update import gqt_pkg::*; #(
    parameter int MAX_SIDE    = 8,
    parameter int VALUE_WIDTH = 16
) (
    input logic       clk,
    input logic       rst_n,
    gqt_cmd_if.sink   cmd,
    gqt_res_if.source res,
    gqt_cfg_if.sink   cfg
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int VW     = VALUE_WIDTH;

    localparam logic signed [VW-1:0] D_GOOD  = VW'(FRAC_ONE);
    localparam logic signed [VW-1:0] D_BAD   = VW'(-FRAC_ONE);
    localparam logic signed [VW-1:0] D_OTHER = VW'(-FRAC_TENTH);
    localparam logic signed [VW-1:0] Q_WALL  = VW'(-FRAC_ONE);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic signed [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1])
        begin
            return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        return s[VW-1:0];
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_CFG_W-1:0] n);
        if (n == '0)
        begin
            return SIDE_W'(1);
        end
        if (32'(n) > MAX_SIDE)
        begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(n);
    endfunction

    // Configuration registers.
    logic [SIDE_CFG_W-1:0] grid_cols_reg;
    logic [SIDE_CFG_W-1:0] grid_rows_reg;
    logic [CELL_W-1:0]     terminal_col_reg;
    logic [CELL_W-1:0]     good_row_reg;
    logic [CELL_W-1:0]     bad_row_reg;

    // Agent state.
    logic [POS_W-1:0]     pos_col_reg, pos_col_next;
    logic [POS_W-1:0]     pos_row_reg, pos_row_next;
    logic signed [VW-1:0] reward_reg, reward_next;

    // Command held between issue and completion.
    logic              state_reg, state_next;
    logic              op_reg;
    logic [ACT_W-1:0]  act_reg;
    logic              move_ok_reg;
    logic              term_reg;
    logic              rd_range_reg;
    logic [ADDR_W-1:0] old_addr_reg;
    logic [POS_W-1:0]  new_col_reg;
    logic [POS_W-1:0]  new_row_reg;

    // Result register.
    logic                     out_valid_reg;
    logic [CELL_W-1:0]        out_col_reg;
    logic [CELL_W-1:0]        out_row_reg;
    logic signed [QOUT_W-1:0] out_q_reg;
    logic                     out_wall_reg;
    logic                     out_end_reg;

    // Issue-side logic.
    logic [SIDE_W-1:0] cols_eff, rows_eff;
    logic [SIDE_W-1:0] col_w, row_w, new_col_w, new_row_w;
    logic              under;
    logic              move_ok;
    logic              term_hit;
    logic [POS_W-1:0]  new_col, new_row;
    logic              rd_range;
    logic [ADDR_W-1:0] new_addr, rd_addr, old_addr;
    logic              accept;
    logic              finish;

    // Completion-side logic.
    tbl_ctl_t                 tctl;
    logic [ADDR_W-1:0]        taddr;
    logic [LANES*VW-1:0]      rd_word;
    logic signed [VW-1:0]     lane_val [LANES];
    logic signed [VW-1:0]     max_a, max_b, cell_max;
    logic signed [VW-1:0]     step_q;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg    <= SIDE_CFG_W'(3);
            grid_rows_reg    <= SIDE_CFG_W'(2);
            terminal_col_reg <= CELL_W'(2);
            good_row_reg     <= CELL_W'(1);
            bad_row_reg      <= CELL_W'(0);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GRID_COLS:    grid_cols_reg    <= cfg.data;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg.data;
                REG_TERMINAL_COL: terminal_col_reg <= cfg.data[CELL_W-1:0];
                REG_GOOD_ROW:     good_row_reg     <= cfg.data[CELL_W-1:0];
                REG_BAD_ROW:      bad_row_reg      <= cfg.data[CELL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Work out the target cell, whether it lies inside the grid, the read range and the table addresses.
    always_comb
    begin
        cols_eff  = clamp_side(grid_cols_reg);
        rows_eff  = clamp_side(grid_rows_reg);
        col_w     = SIDE_W'(pos_col_reg);
        row_w     = SIDE_W'(pos_row_reg);
        new_col_w = col_w;
        new_row_w = row_w;
        under     = 1'b0;
        case (cmd.action)
            ACT_UP:
            begin
                new_row_w = row_w + SIDE_W'(1);
            end
            ACT_DOWN:
            begin
                under     = (row_w == '0);
                new_row_w = row_w - SIDE_W'(1);
            end
            ACT_LEFT:
            begin
                under     = (col_w == '0);
                new_col_w = col_w - SIDE_W'(1);
            end
            default:
            begin
                new_col_w = col_w + SIDE_W'(1);
            end
        endcase
        move_ok  = !under && (new_col_w < cols_eff) && (new_row_w < rows_eff);
        new_col  = POS_W'(new_col_w);
        new_row  = POS_W'(new_row_w);
        term_hit = (32'(new_col) == 32'(terminal_col_reg));
        rd_range = (32'(cmd.read_col) < MAX_SIDE) && (32'(cmd.read_row) < MAX_SIDE);
        new_addr = ADDR_W'(32'(new_row) * MAX_SIDE + 32'(new_col));
        rd_addr  = ADDR_W'(32'(POS_W'(cmd.read_row)) * MAX_SIDE + 32'(POS_W'(cmd.read_col)));
        old_addr = ADDR_W'(32'(pos_row_reg) * MAX_SIDE + 32'(pos_col_reg));
    end

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && (state_reg == ST_IDLE);
    // A command waits in the EXEC state until the result slot is free.
    assign finish    = (state_reg == ST_EXEC) && (!out_valid_reg || res.ready);

    always_comb
    begin
        for (int lane = 0; lane < LANES; lane++)
        begin
            lane_val[lane] = rd_word[lane*VW +: VW];
        end
        max_a    = (lane_val[1] > lane_val[0]) ? lane_val[1] : lane_val[0];
        max_b    = (lane_val[3] > lane_val[2]) ? lane_val[3] : lane_val[2];
        cell_max = (max_b > max_a) ? max_b : max_a;
        step_q   = move_ok_reg ? sat_add(reward_reg, cell_max) : Q_WALL;
    end

    always_comb
    begin
        tctl.rd_en   = 1'b0;
        tctl.wr_en   = 1'b0;
        tctl.wr_lane = act_reg;
        taddr        = old_addr_reg;
        if (accept)
        begin
            if (cmd.op == OP_READ)
            begin
                tctl.rd_en = rd_range;
                taddr      = rd_addr;
            end
            else
            begin
                tctl.rd_en = move_ok;
                taddr      = new_addr;
            end
        end
        else if (finish && op_reg == OP_STEP)
        begin
            tctl.wr_en = 1'b1;
        end
    end

    gqt_table #(
        .DEPTH       (DEPTH),
        .ADDR_W      (ADDR_W),
        .VALUE_WIDTH (VW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tctl),
        .addr     (taddr),
        .wr_value (step_q),
        .rd_word  (rd_word)
    );

    always_comb
    begin
        state_next   = state_reg;
        pos_col_next = pos_col_reg;
        pos_row_next = pos_row_reg;
        reward_next  = reward_reg;
        if (accept)
        begin
            state_next = ST_EXEC;
            // The reward sum moves on issue; the target cell's value arrives next cycle.
            if (cmd.op == OP_STEP && move_ok)
            begin
                if (term_hit && 32'(new_row) == 32'(good_row_reg))
                begin
                    reward_next = sat_add(reward_reg, D_GOOD);
                end
                else if (term_hit && 32'(new_row) == 32'(bad_row_reg))
                begin
                    reward_next = sat_add(reward_reg, D_BAD);
                end
                else
                begin
                    reward_next = sat_add(reward_reg, D_OTHER);
                end
            end
        end
        else if (finish)
        begin
            state_next = ST_IDLE;
            if (op_reg == OP_STEP)
            begin
                if (move_ok_reg && !term_reg)
                begin
                    pos_col_next = new_col_reg;
                    pos_row_next = new_row_reg;
                end
                else
                begin
                    pos_col_next = '0;
                    pos_row_next = '0;
                    reward_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_col_reg   <= '0;
            pos_row_reg   <= '0;
            reward_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_col_reg <= pos_col_next;
            pos_row_reg <= pos_row_next;
            reward_reg  <= reward_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= cmd.op;
            act_reg      <= cmd.action;
            move_ok_reg  <= move_ok;
            term_reg     <= term_hit;
            rd_range_reg <= rd_range;
            old_addr_reg <= old_addr;
            new_col_reg  <= new_col;
            new_row_reg  <= new_row;
        end
        if (finish)
        begin
            out_col_reg  <= CELL_W'(pos_col_next);
            out_row_reg  <= CELL_W'(pos_row_next);
            if (op_reg == OP_READ)
            begin
                out_q_reg    <= rd_range_reg ? QOUT_W'(lane_val[act_reg]) : '0;
                out_wall_reg <= 1'b0;
                out_end_reg  <= 1'b0;
            end
            else
            begin
                out_q_reg    <= QOUT_W'(step_q);
                out_wall_reg <= !move_ok_reg;
                out_end_reg  <= !move_ok_reg || term_reg;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.agent_col   = out_col_reg;
    assign res.agent_row   = out_row_reg;
    assign res.q_value     = out_q_reg;
    assign res.hit_wall    = out_wall_reg;
    assign res.episode_end = out_end_reg;

endmodule

FILE: tb/gridworld_q_table_update_tb.sv
`timescale 1ns / 100ps

module gridworld_q_table_update_tb import gqt_pkg::*; ();

    localparam int SIDE           = 8;
    localparam int CELLS          = SIDE * SIDE;
    localparam int Q_MAX          = 2 ** (QOUT_W - 1) - 1;
    localparam int Q_MIN          = -Q_MAX - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // Highest index of the register port; nothing is mapped there.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
        logic [QOUT_W-1:0] q;
        logic              wall;
        logic              done;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    gqt_cmd_if cmd_bus ();
    gqt_res_if res_bus ();
    gqt_cfg_if cfg_bus ();

    gridworld_q_table_update #(
        .MAX_SIDE    (SIDE),
        .VALUE_WIDTH (QOUT_W)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus),
        .cfg   (cfg_bus)
    );

    // Shadow copy of the learner: table, agent, reward sum and registers.
    int                    q_mem [CELLS][LANES];
    logic [CELL_W-1:0]     agent_c;
    logic [CELL_W-1:0]     agent_r;
    int                    reward_acc;
    logic [SIDE_CFG_W-1:0] cols_reg;
    logic [SIDE_CFG_W-1:0] rows_reg;
    logic [CELL_W-1:0]     term_reg;
    logic [CELL_W-1:0]     good_reg;
    logic [CELL_W-1:0]     bad_reg;

    outcome_t expected_outcomes[$];
    int       errors;
    int       quiet_cycles;
    int       stall_left;
    bit       quiet;
    int       idle_pct;
    int       stall_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int clip_q(input int v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    function automatic int eff_side(input logic [SIDE_CFG_W-1:0] n);
        if (n == 0)
        begin
            return 1;
        end
        if (int'(n) > SIDE)
        begin
            return SIDE;
        end
        return int'(n);
    endfunction

    // Target cell of a move from the current agent position; true if it lies
    // inside the grid as it is configured now.
    function automatic bit move_target(input logic [ACT_W-1:0] act, output int nc,
                                       output int nr);
        nc = int'(agent_c);
        nr = int'(agent_r);
        case (act)
            ACT_UP:   nr = nr + 1;
            ACT_DOWN: nr = nr - 1;
            ACT_LEFT: nc = nc - 1;
            default:  nc = nc + 1;
        endcase
        return nc >= 0 && nr >= 0 && nc < eff_side(cols_reg) && nr < eff_side(rows_reg);
    endfunction

    function automatic int best_lane(input int idx);
        int m;
        m = q_mem[idx][0];
        for (int k = 1; k < LANES; k++)
        begin
            if (q_mem[idx][k] > m)
            begin
                m = q_mem[idx][k];
            end
        end
        return m;
    endfunction

    function automatic void reset_learner();
        for (int i = 0; i < CELLS; i++)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                q_mem[i][k] = 0;
            end
        end
        agent_c    = '0;
        agent_r    = '0;
        reward_acc = 0;
        cols_reg   = 4'd3;
        rows_reg   = 4'd2;
        term_reg   = 3'd2;
        good_reg   = 3'd1;
        bad_reg    = 3'd0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_GRID_COLS:    cols_reg = val;
            REG_GRID_ROWS:    rows_reg = val;
            REG_TERMINAL_COL: term_reg = val[CELL_W-1:0];
            REG_GOOD_ROW:     good_reg = val[CELL_W-1:0];
            REG_BAD_ROW:      bad_reg  = val[CELL_W-1:0];
            default:          ;
        endcase
    endfunction

    // Runs one command word through the shadow learner and returns the
    // result word the block must produce for it.
    function automatic outcome_t apply_command(input logic op, input logic [ACT_W-1:0] act,
                                               input logic [CELL_W-1:0] rc,
                                               input logic [CELL_W-1:0] rr);
        outcome_t o;
        int       nc;
        int       nr;
        int       old_idx;
        int       delta;
        int       qv;
        qv     = 0;
        o.wall = 1'b0;
        o.done = 1'b0;
        if (op == OP_READ)
        begin
            qv = q_mem[int'(rr) * SIDE + int'(rc)][act];
        end
        else
        begin
            old_idx = int'(agent_r) * SIDE + int'(agent_c);
            if (move_target(act, nc, nr))
            begin
                // The good reward takes precedence when both rows coincide.
                if (nc == int'(term_reg) && nr == int'(good_reg))
                begin
                    delta = FRAC_ONE;
                end
                else if (nc == int'(term_reg) && nr == int'(bad_reg))
                begin
                    delta = -FRAC_ONE;
                end
                else
                begin
                    delta = -FRAC_TENTH;
                end
                reward_acc = clip_q(reward_acc + delta);
                qv         = clip_q(reward_acc + best_lane(nr * SIDE + nc));
                q_mem[old_idx][act] = qv;
                agent_c = nc[CELL_W-1:0];
                agent_r = nr[CELL_W-1:0];
                if (nc == int'(term_reg))
                begin
                    agent_c    = '0;
                    agent_r    = '0;
                    reward_acc = 0;
                    o.done     = 1'b1;
                end
            end
            else
            begin
                qv = clip_q(-FRAC_ONE);
                q_mem[old_idx][act] = qv;
                agent_c    = '0;
                agent_r    = '0;
                reward_acc = 0;
                o.wall     = 1'b1;
                o.done     = 1'b1;
            end
        end
        o.col = agent_c;
        o.row = agent_r;
        o.q   = qv[QOUT_W-1:0];
        return o;
    endfunction

    // Mostly picks a move that stays on the grid, so that episodes run long.
    function automatic logic [ACT_W-1:0] pick_action(input int legal_pct);
        logic [ACT_W-1:0] fits [LANES];
        logic [ACT_W-1:0] a;
        int               n;
        int               nc;
        int               nr;
        n = 0;
        if ($urandom_range(0, 99) < legal_pct)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                a = k[ACT_W-1:0];
                if (move_target(a, nc, nr))
                begin
                    fits[n] = a;
                    n++;
                end
            end
        end
        if (n == 0)
        begin
            return ACT_W'($urandom_range(0, LANES - 1));
        end
        return fits[$urandom_range(0, n - 1)];
    endfunction

    // Result checking, prediction and watchdog all sample at the rising edge.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (res_bus.valid && res_bus.ready)
            begin
                moved    = 1'b1;
                got.col  = res_bus.agent_col;
                got.row  = res_bus.agent_row;
                got.q    = res_bus.q_value;
                got.wall = res_bus.hit_wall;
                got.done = res_bus.episode_end;
                if (expected_outcomes.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                    begin
                        $display("%0t: result word with nothing pending: col %0d row %0d q %0d",
                                 $time, got.col, got.row, $signed(got.q));
                    end
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got.col !== want.col || got.row !== want.row || got.q !== want.q ||
                        got.wall !== want.wall || got.done !== want.done)
                    begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: expected col %0d row %0d q %0d wall %0b end %0b",
                                     $time, want.col, want.row, $signed(want.q), want.wall,
                                     want.done);
                            $display("%0t:           got      col %0d row %0d q %0d wall %0b end %0b",
                                     $time, got.col, got.row, $signed(got.q), got.wall, got.done);
                        end
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                moved = 1'b1;
                apply_register(cfg_bus.index, cfg_bus.data);
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                moved = 1'b1;
                expected_outcomes.push_back(apply_command(cmd_bus.op, cmd_bus.action,
                                                          cmd_bus.read_col, cmd_bus.read_row));
            end
            if (moved)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("gridworld_q_table_update verification failed");
                    $finish;
                end
            end
        end
    end

    // Result-side backpressure in random bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0 && !quiet)
        begin
            stall_left--;
            res_bus.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            res_bus.ready <= 1'b0;
        end
        else
        begin
            res_bus.ready <= 1'b1;
        end
    end

    // Called just after a falling edge; returns at the falling edge after the
    // word was taken, with valid still high.
    task automatic send_word(input logic op, input logic [ACT_W-1:0] act,
                             input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row);
        int gap;
        if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 11);
            cmd_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.valid    = 1'b1;
        cmd_bus.op       = op;
        cmd_bus.action   = act;
        cmd_bus.read_col = col;
        cmd_bus.read_row = row;
        do @(posedge clk); while (!cmd_bus.ready);
        @(negedge clk);
    endtask

    task automatic step_to(input logic [ACT_W-1:0] act);
        send_word(OP_STEP, act, CELL_W'($urandom_range(0, 7)), CELL_W'($urandom_range(0, 7)));
    endtask

    task automatic peek(input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
                        input logic [ACT_W-1:0] act);
        send_word(OP_READ, act, col, row);
    endtask

    task automatic drain();
        cmd_bus.valid = 1'b0;
        while (expected_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        do @(posedge clk); while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
        @(negedge clk);
    endtask

    task automatic write_grid(input logic [CFG_DATA_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] rows,
                              input logic [CFG_DATA_W-1:0] term,
                              input logic [CFG_DATA_W-1:0] good,
                              input logic [CFG_DATA_W-1:0] bad);
        write_reg(REG_GRID_COLS, cols);
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_TERMINAL_COL, term);
        write_reg(REG_GOOD_ROW, good);
        write_reg(REG_BAD_ROW, bad);
    endtask

    task automatic random_grid();
        logic [CFG_DATA_W-1:0] cols;
        logic [CFG_DATA_W-1:0] rows;
        cols = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                           : CFG_DATA_W'($urandom_range(2, 8));
        rows = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(0, 15))
                                           : CFG_DATA_W'($urandom_range(2, 8));
        write_grid(cols, rows, CFG_DATA_W'($urandom_range(0, 15)),
                   CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
    endtask

    task automatic random_item(input int legal_pct, input int read_pct);
        if ($urandom_range(0, 99) < read_pct)
        begin
            peek(CELL_W'($urandom_range(0, 7)), CELL_W'($urandom_range(0, 7)),
                 ACT_W'($urandom_range(0, 3)));
        end
        else
        begin
            send_word(OP_STEP, pick_action(legal_pct), CELL_W'($urandom_range(0, 7)),
                      CELL_W'($urandom_range(0, 7)));
        end
    endtask

    task automatic test_reset_readout();
        peek(0, 0, ACT_UP);
        peek(7, 7, ACT_RIGHT);
    endtask

    // Default 3x2 grid: bad cell at (2,0), good cell at (2,1).
    task automatic test_rewards_and_walls();
        step_to(ACT_DOWN);
        step_to(ACT_RIGHT);
        step_to(ACT_RIGHT);
        step_to(ACT_UP);
        step_to(ACT_RIGHT);
        step_to(ACT_RIGHT);
        step_to(ACT_UP);
        step_to(ACT_UP);
        step_to(ACT_LEFT);
        peek(1, 0, ACT_RIGHT);
    endtask

    // Zero sizes act as one cell; oversized ones act as the full side. The
    // walk ends on a cell that is both the good and the bad one.
    task automatic test_grid_clamp();
        drain();
        write_grid(0, 0, 2, 1, 0);
        step_to(ACT_UP);
        step_to(ACT_RIGHT);
        drain();
        write_grid(15, 15, 7, 0, 0);
        repeat (7) step_to(ACT_RIGHT);
    endtask

    // The grid shrinks under the agent, and the terminal column moves off it.
    task automatic test_shrunk_grid();
        drain();
        write_grid(8, 8, 7, 7, 0);
        step_to(ACT_UP);
        step_to(ACT_RIGHT);
        step_to(ACT_RIGHT);
        drain();
        write_grid(2, 1, 5, 0, 7);
        step_to(ACT_DOWN);
        peek(2, 1, ACT_DOWN);
        step_to(ACT_RIGHT);
    endtask

    task automatic test_random_walk();
        for (int p = 0; p < 6; p++)
        begin
            drain();
            case (p)
                0:       write_grid(8, 8, 7, 7, 0);
                1:       write_grid(1, 8, 0, 0, 7);
                2:       write_grid(4, 3, 3, 2, 2);
                default: random_grid();
            endcase
            if (p == 3)
            begin
                write_reg(REG_UNMAPPED, 4'hF);
            end
            idle_pct  = (p % 3) * 20;
            stall_pct = ((p + 1) % 3) * 20;
            repeat (90) random_item(75, 20);
        end
    endtask

    // A one-column corridor with no terminal on the grid: shuttling up and
    // down feeds each cell's value into the other.
    task automatic test_narrow_corridor();
        drain();
        write_grid(1, 2, 7, 7, 7);
        idle_pct  = 10;
        stall_pct = 10;
        repeat (130) random_item(95, 5);
    endtask

    task automatic test_full_rate();
        drain();
        quiet = 1'b1;
        random_grid();
        repeat (150) random_item(70, 20);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.op       = OP_STEP;
        cmd_bus.action   = ACT_UP;
        cmd_bus.read_col = '0;
        cmd_bus.read_row = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_GRID_COLS;
        cfg_bus.data     = '0;
        res_bus.ready    = 1'b0;
        errors           = 0;
        quiet_cycles     = 0;
        stall_left       = 0;
        quiet            = 1'b0;
        idle_pct         = 20;
        stall_pct        = 20;
        reset_learner();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_readout();
        test_rewards_and_walls();
        test_grid_clamp();
        test_shrunk_grid();
        test_random_walk();
        test_narrow_corridor();
        test_full_rate();

        drain();
        repeat (8) @(posedge clk);
        errors += expected_outcomes.size();
        if (errors == 0)
        begin
            $display("gridworld_q_table_update verification clean");
        end
        else
        begin
            $display("gridworld_q_table_update verification failed");
        end
        $finish;
    end

endmodule
